FILE: sv/apt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 2D affine point transform.
// No dependencies; imported by every module of the block.
package apt_pkg;

    // Configuration register indexes on the write port.
    typedef enum logic [2:0] {
        CFG_KIND     = 3'd0,
        CFG_OFFSET_X = 3'd1,
        CFG_OFFSET_Y = 3'd2,
        CFG_SCALE_X  = 3'd3,
        CFG_SCALE_Y  = 3'd4,
        CFG_ANGLE    = 3'd5
    } cfg_idx_t;

    // Transform kinds; codes 6 and 7 fall to identity.
    typedef enum logic [2:0] {
        KIND_TRANSLATE    = 3'd0,
        KIND_SCALE        = 3'd1,
        KIND_SCALE_PIVOT  = 3'd2,
        KIND_ROTATE       = 3'd3,
        KIND_ROTATE_INV   = 3'd4,
        KIND_ROTATE_PIVOT = 3'd5
    } kind_t;

    // Fraction bits dropped (with round half up) after each product.
    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_Q8   = 2'd1,
        SHIFT_Q14  = 2'd2
    } shift_t;

    localparam int Q8_FRAC  = 8;
    localparam int Q14_FRAC = 14;
    localparam int Q8_ONE   = 256;
    localparam int Q14_ONE  = 16384;

    localparam int CFG_DATA_W = 16;
    localparam int RES_W      = 24;

    // Cycles from a config write until the matrix registers are settled.
    localparam int COEF_LAT = 3;

    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [8:0]         angle_deg;
    } cfg_t;

    // Matrix for row-vector form: out_x = x*m00 + y*m10 + w*m20,
    // out_y = x*m01 + y*m11 + w*m21, each product rounded by shift.
    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        shift_t             shift;
    } coef_t;

    // Quarter-wave sine, Q1.14, whole degrees 0..90.
    localparam logic [14:0] SIN_TABLE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // Sine of d degrees, d in 0..359, Q1.14.
    function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
        logic [8:0]  idx;
        logic        neg;
        logic [14:0] mag;
        if (d <= DEG_90) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= DEG_180) begin
            idx = DEG_180 - d;
            neg = 1'b0;
        end else if (d <= DEG_270) begin
            idx = d - DEG_180;
            neg = 1'b1;
        end else begin
            idx = DEG_360 - d;
            neg = 1'b1;
        end
        mag = SIN_TABLE[idx[6:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

FILE: sv/affine_point_transform_2d.sv
`timescale 1ns / 1ps
// Top level of the 2D homogeneous affine vertex transform.
// Instantiates apt_coef and apt_datapath; uses apt_pkg.
//
// Each slave transaction carries one vertex row [x y w]; the block returns
// [x y w] * M on the master side, one result per vertex, in order, w and
// tlast passed through. M is built from the configuration registers
// (translate, scale, scale about pivot, rotate, inverse rotate, rotate
// about pivot; kinds 6 and 7 are identity). Every product is rounded half
// up before the three are summed, and x/y are saturated to 24 bits.
// Throughput is one vertex per clock while the sink accepts and the
// matrix is settled. The input register loads at the accepting edge, then
// the product register, then the result register, which drives tvalid;
// each stage stalls only when the one after it is full.
// The matrix comes from a three-stage builder (sine/cosine table, pivot
// products, select), so s_tready stays low after reset and after each
// configuration write until the matrix registers have settled. Write
// configuration only while no vertex is in flight.
module affine_point_transform_2d
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave: tdata = vertex_x, vertex_y, vertex_w from bit 0 up, zero padded
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tlast,     // last_vertex
    // master: tdata = out_x[23:0], out_y[23:0], out_w from bit 0 up, zero padded
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((48+COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                                m_tlast,     // out_last
    // configuration write port
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [apt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import apt_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = ((48 + COORD_WIDTH + 7) / 8) * 8;
    localparam int BUSY_W = $clog2(COEF_LAT + 1);

    cfg_t  cfg_reg;
    coef_t coef;

    logic [BUSY_W-1:0] busy_reg, busy_next;

    logic signed [23:0]   out_x;
    logic signed [23:0]   out_y;
    logic signed [CW-1:0] out_w;

    // Configuration registers and settle counter.
    always_comb
    begin
        if (cfg_we)
            busy_next = BUSY_W'(COEF_LAT);
        else if (busy_reg != '0)
            busy_next = busy_reg - 1'b1;
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind      <= KIND_TRANSLATE;
            cfg_reg.offset_x  <= '0;
            cfg_reg.offset_y  <= '0;
            cfg_reg.scale_x   <= 16'(Q8_ONE);
            cfg_reg.scale_y   <= 16'(Q8_ONE);
            cfg_reg.angle_deg <= '0;
            busy_reg          <= BUSY_W'(COEF_LAT);
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KIND:     cfg_reg.kind      <= kind_t'(cfg_data[2:0]);
                    CFG_OFFSET_X: cfg_reg.offset_x  <= cfg_data;
                    CFG_OFFSET_Y: cfg_reg.offset_y  <= cfg_data;
                    CFG_SCALE_X:  cfg_reg.scale_x   <= cfg_data;
                    CFG_SCALE_Y:  cfg_reg.scale_y   <= cfg_data;
                    CFG_ANGLE:    cfg_reg.angle_deg <= cfg_data[8:0];
                    default:      ;  // unmapped index, ignored
                endcase
            end
        end
    end

    apt_coef u_coef
    (
        .clk  (clk),
        .cfg  (cfg_reg),
        .coef (coef)
    );

    apt_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (s_tvalid),
        .in_block  (busy_reg != '0),
        .in_ready  (s_tready),
        .in_x      (s_tdata[CW-1:0]),
        .in_y      (s_tdata[2*CW-1:CW]),
        .in_w      (s_tdata[3*CW-1:2*CW]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_w     (out_w),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_W'({out_w, out_y, out_x});

    // No transaction is taken while the matrix is still settling.
    property p_settle_after_write;
        @(posedge clk) disable iff (!rst_n)
        s_tready |-> !$past(cfg_we, 1) && !$past(cfg_we, 2) && !$past(cfg_we, 3);
    endproperty
    a_settle_after_write: assert property (p_settle_after_write)
        else $error("s_tready high within settle window after a config write");

    // An empty pipeline never blocks the input once settled.
    property p_ready_when_empty;
        @(posedge clk) disable iff (!rst_n)
        (!m_tvalid && busy_reg == '0) |-> s_tready;
    endproperty
    a_ready_when_empty: assert property (p_ready_when_empty)
        else $error("input stalled with an empty result register");

    // A draining sink keeps full rate.
    property p_full_rate;
        @(posedge clk) disable iff (!rst_n)
        (m_tready && busy_reg == '0) |-> s_tready;
    endproperty
    a_full_rate: assert property (p_full_rate)
        else $error("input stalled while the sink accepts every cycle");

endmodule

FILE: sv/apt_coef.sv
`timescale 1ns / 1ps
// Matrix builder: turns the configuration registers into matrix entries.
// Three register stages (trig lookup, products, select). Uses apt_pkg.
module apt_coef
(
    input  logic          clk,
    input  apt_pkg::cfg_t cfg,
    output apt_pkg::coef_t coef
);
    import apt_pkg::*;

    logic [8:0]         ang_mod;
    logic [8:0]         cos_arg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    logic signed [16:0] one_minus_c;
    logic signed [16:0] one_minus_kx;
    logic signed [16:0] one_minus_ky;

    logic signed [32:0] tx_omc_reg, tx_omc_next;
    logic signed [32:0] ty_omc_reg, ty_omc_next;
    logic signed [32:0] tx_s_reg,   tx_s_next;
    logic signed [32:0] ty_s_reg,   ty_s_next;
    logic signed [32:0] tx_okx_reg, tx_okx_next;
    logic signed [32:0] ty_oky_reg, ty_oky_next;

    coef_t coef_reg, coef_next;

    // Stage 1: angle mod 360, sine and cosine.
    always_comb
    begin
        ang_mod = (cfg.angle_deg >= DEG_360) ? cfg.angle_deg - DEG_360 : cfg.angle_deg;
        cos_arg = (ang_mod >= DEG_270) ? ang_mod - DEG_270 : ang_mod + DEG_90;
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_deg(ang_mod);
        cos_reg <= sin_deg(cos_arg);
    end

    // Stage 2: pivot products.
    always_comb
    begin
        one_minus_c  = 17'(Q14_ONE) - 17'(cos_reg);
        one_minus_kx = 17'(Q8_ONE) - 17'(cfg.scale_x);
        one_minus_ky = 17'(Q8_ONE) - 17'(cfg.scale_y);
        tx_omc_next  = cfg.offset_x * one_minus_c;
        ty_omc_next  = cfg.offset_y * one_minus_c;
        tx_s_next    = cfg.offset_x * 17'(sin_reg);
        ty_s_next    = cfg.offset_y * 17'(sin_reg);
        tx_okx_next  = cfg.offset_x * one_minus_kx;
        ty_oky_next  = cfg.offset_y * one_minus_ky;
    end

    always_ff @(posedge clk)
    begin
        tx_omc_reg <= tx_omc_next;
        ty_omc_reg <= ty_omc_next;
        tx_s_reg   <= tx_s_next;
        ty_s_reg   <= ty_s_next;
        tx_okx_reg <= tx_okx_next;
        ty_oky_reg <= ty_oky_next;
    end

    // Stage 3: assemble the matrix for the selected kind.
    always_comb
    begin
        coef_next.m00   = 16'sd1;
        coef_next.m01   = '0;
        coef_next.m10   = '0;
        coef_next.m11   = 16'sd1;
        coef_next.m20   = '0;
        coef_next.m21   = '0;
        coef_next.shift = SHIFT_NONE;
        case (cfg.kind)
            KIND_TRANSLATE:
            begin
                coef_next.m20 = 32'(cfg.offset_x);
                coef_next.m21 = 32'(cfg.offset_y);
            end
            KIND_SCALE:
            begin
                coef_next.m00   = cfg.scale_x;
                coef_next.m11   = cfg.scale_y;
                coef_next.shift = SHIFT_Q8;
            end
            KIND_SCALE_PIVOT:
            begin
                coef_next.m00   = cfg.scale_x;
                coef_next.m11   = cfg.scale_y;
                coef_next.m20   = 32'(tx_okx_reg);
                coef_next.m21   = 32'(ty_oky_reg);
                coef_next.shift = SHIFT_Q8;
            end
            KIND_ROTATE:
            begin
                coef_next.m00   = cos_reg;
                coef_next.m01   = sin_reg;
                coef_next.m10   = -sin_reg;
                coef_next.m11   = cos_reg;
                coef_next.shift = SHIFT_Q14;
            end
            KIND_ROTATE_INV:
            begin
                coef_next.m00   = cos_reg;
                coef_next.m01   = -sin_reg;
                coef_next.m10   = sin_reg;
                coef_next.m11   = cos_reg;
                coef_next.shift = SHIFT_Q14;
            end
            KIND_ROTATE_PIVOT:
            begin
                coef_next.m00   = cos_reg;
                coef_next.m01   = sin_reg;
                coef_next.m10   = -sin_reg;
                coef_next.m11   = cos_reg;
                // both sums stay inside 32 bits signed
                coef_next.m20   = 32'(tx_omc_reg + ty_s_reg);
                coef_next.m21   = 32'(ty_omc_reg - tx_s_reg);
                coef_next.shift = SHIFT_Q14;
            end
            default:
            begin
                coef_next.shift = SHIFT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

FILE: sv/apt_datapath.sv
`timescale 1ns / 1ps
// Vertex pipeline: input register, product register, rounded/saturated result.
// Three stages with per-stage valid bits and stall. Uses apt_pkg.
module apt_datapath
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  apt_pkg::coef_t                coef,
    input  logic                          in_valid,
    input  logic                          in_block,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_w,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [23:0]            out_x,
    output logic signed [23:0]            out_y,
    output logic signed [COORD_WIDTH-1:0] out_w,
    output logic                          out_last
);
    import apt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PS = CW + 16;   // coordinate by 16-bit entry
    localparam int PW = CW + 32;   // w by 32-bit entry
    localparam int SW = CW + 34;   // sum of three rounded products

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic adv_a, adv_b, adv_c;
    logic accept;

    logic signed [CW-1:0] a_x_reg, a_y_reg, a_w_reg;
    logic                 a_last_reg;

    logic signed [PS-1:0] b_xm00_reg, b_xm01_reg, b_ym10_reg, b_ym11_reg;
    logic signed [PW-1:0] b_wm20_reg, b_wm21_reg;
    logic signed [CW-1:0] b_w_reg;
    logic                 b_last_reg;
    shift_t               b_shift_reg;

    logic signed [PS-1:0] xm00_next, xm01_next, ym10_next, ym11_next;
    logic signed [PW-1:0] wm20_next, wm21_next;

    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [23:0]   sat_x, sat_y;

    logic signed [23:0]   c_x_reg, c_y_reg;
    logic signed [CW-1:0] c_w_reg;
    logic                 c_last_reg;

    // floor((v + half) / 2^sh)
    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v,
                                                 input shift_t sh);
        logic signed [SW-1:0] r;
        case (sh)
            SHIFT_Q8:  r = (v + (SW'(1) <<< (Q8_FRAC - 1))) >>> Q8_FRAC;
            SHIFT_Q14: r = (v + (SW'(1) <<< (Q14_FRAC - 1))) >>> Q14_FRAC;
            default:   r = v;
        endcase
        return r;
    endfunction

    function automatic logic signed [23:0] sat(input logic signed [SW-1:0] v);
        logic [SW-RES_W:0] top;
        top = v[SW-1:RES_W-1];
        if ((&top) || !(|top))
            return v[RES_W-1:0];
        else
            return v[SW-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    endfunction

    assign adv_c    = !c_valid_reg || out_ready;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a && !in_block;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                a_valid_reg <= accept;
            if (adv_b)
                b_valid_reg <= a_valid_reg;
            if (adv_c)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Stage A: input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg    <= in_x;
            a_y_reg    <= in_y;
            a_w_reg    <= in_w;
            a_last_reg <= in_last;
        end
    end

    // Stage B: six products
    always_comb
    begin
        xm00_next = a_x_reg * coef.m00;
        xm01_next = a_x_reg * coef.m01;
        ym10_next = a_y_reg * coef.m10;
        ym11_next = a_y_reg * coef.m11;
        wm20_next = a_w_reg * coef.m20;
        wm21_next = a_w_reg * coef.m21;
    end

    always_ff @(posedge clk)
    begin
        if (adv_b && a_valid_reg)
        begin
            b_xm00_reg  <= xm00_next;
            b_xm01_reg  <= xm01_next;
            b_ym10_reg  <= ym10_next;
            b_ym11_reg  <= ym11_next;
            b_wm20_reg  <= wm20_next;
            b_wm21_reg  <= wm21_next;
            b_w_reg     <= a_w_reg;
            b_last_reg  <= a_last_reg;
            b_shift_reg <= coef.shift;
        end
    end

    // Stage C: round each product, sum, saturate
    always_comb
    begin
        sum_x = rnd(SW'(b_xm00_reg), b_shift_reg) + rnd(SW'(b_ym10_reg), b_shift_reg)
              + rnd(SW'(b_wm20_reg), b_shift_reg);
        sum_y = rnd(SW'(b_xm01_reg), b_shift_reg) + rnd(SW'(b_ym11_reg), b_shift_reg)
              + rnd(SW'(b_wm21_reg), b_shift_reg);
        sat_x = sat(sum_x);
        sat_y = sat(sum_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv_c && b_valid_reg)
        begin
            c_x_reg    <= sat_x;
            c_y_reg    <= sat_y;
            c_w_reg    <= b_w_reg;
            c_last_reg <= b_last_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_x     = c_x_reg;
    assign out_y     = c_y_reg;
    assign out_w     = c_w_reg;
    assign out_last  = c_last_reg;

endmodule

FILE: bench/affine_point_transform_2d_test.sv
`timescale 1ns / 1ps
// Self-checking bench for affine_point_transform_2d: streams vertex rows, predicts each row.
// Depends on apt_pkg (register indexes, transform kinds) and the block's RTL only.
module affine_point_transform_2d_test;

    import apt_pkg::*;

    localparam int COORD_W  = 16;
    localparam int S_DATA_W = ((3 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((48 + COORD_W + 7) / 8) * 8;

    // Kind codes past the last defined kind; the block treats them as identity.
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam int Q8_BITS  = 8;
    localparam int Q14_BITS = 14;
    localparam longint Q8_UNIT  = 256;
    localparam longint Q14_UNIT = 16384;
    localparam longint RES_MAX  = 64'sd8388607;
    localparam longint RES_MIN  = -64'sd8388608;

    localparam int RANDOM_ROWS    = 800;
    localparam int DRAIN_CYCLES   = 6;     // pipeline depth plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles with no transaction or register write

    // Quarter-wave sine in Q1.14, one entry per whole degree 0..90.
    localparam int QUARTER_SINE [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic                      last;
    } vertex_t;

    typedef struct {
        logic signed [23:0]        x;
        logic signed [23:0]        y;
        logic signed [COORD_W-1:0] w;
        logic                      last;
    } point_t;

    // Bench copy of the configuration registers.
    typedef struct {
        logic [2:0]         kind;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [8:0]         angle;
    } xform_setup_t;

    // Receiver back-pressure modes.
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;

    vertex_t      vertex_backlog [$];   // rows waiting to be offered on the slave side
    point_t       expected_rows [$];    // predicted points, oldest first
    xform_setup_t setup;
    vertex_t      held_vertex;          // row currently offered on the slave side
    int           burst_left   = 0;
    int           gap_left     = 0;
    rx_mode_t     rx_mode      = RX_FLOW;
    int           rx_mode_left = 0;
    int           quiet_cycles = 0;
    int           error_count  = 0;

    affine_point_transform_2d #(
        .COORD_WIDTH (COORD_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Point predictor
    // ---------------------------------------------------------------

    // floor(p / 2^frac + 1/2): arithmetic shift of a signed value floors.
    function automatic longint round_q(input longint p, input int frac);
        return (p + (longint'(1) << (frac - 1))) >>> frac;
    endfunction

    function automatic longint sine_q14(input int unsigned deg);
        int unsigned d;
        d = deg % 360;
        if (d <= 90)
            return QUARTER_SINE[d];
        else if (d <= 180)
            return QUARTER_SINE[180 - d];
        else if (d <= 270)
            return -QUARTER_SINE[d - 180];
        return -QUARTER_SINE[360 - d];
    endfunction

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > RES_MAX)
            return RES_MAX[23:0];
        if (v < RES_MIN)
            return RES_MIN[23:0];
        return v[23:0];
    endfunction

    // Row [x y w] times the matrix the current setup describes.
    function automatic point_t transform_vertex(input vertex_t v);
        point_t      p;
        longint      x, y, w, tx, ty, kx, ky, s, c, e0, e1, ox, oy;
        int unsigned deg;
        x   = v.x;
        y   = v.y;
        w   = v.w;
        tx  = setup.offset_x;
        ty  = setup.offset_y;
        kx  = setup.scale_x;
        ky  = setup.scale_y;
        deg = setup.angle % 360;
        s   = sine_q14(deg);
        c   = sine_q14(deg + 90);
        case (setup.kind)
            KIND_TRANSLATE:
            begin
                ox = x + w * tx;
                oy = y + w * ty;
            end
            KIND_SCALE:
            begin
                ox = round_q(x * kx, Q8_BITS);
                oy = round_q(y * ky, Q8_BITS);
            end
            KIND_SCALE_PIVOT:
            begin
                e0 = tx * (Q8_UNIT - kx);
                e1 = ty * (Q8_UNIT - ky);
                ox = round_q(x * kx, Q8_BITS) + round_q(w * e0, Q8_BITS);
                oy = round_q(y * ky, Q8_BITS) + round_q(w * e1, Q8_BITS);
            end
            KIND_ROTATE:
            begin
                ox = round_q(x * c, Q14_BITS) + round_q(-(y * s), Q14_BITS);
                oy = round_q(x * s, Q14_BITS) + round_q(y * c, Q14_BITS);
            end
            KIND_ROTATE_INV:
            begin
                ox = round_q(x * c, Q14_BITS) + round_q(y * s, Q14_BITS);
                oy = round_q(-(x * s), Q14_BITS) + round_q(y * c, Q14_BITS);
            end
            KIND_ROTATE_PIVOT:
            begin
                e0 = tx * (Q14_UNIT - c) + ty * s;
                e1 = ty * (Q14_UNIT - c) - tx * s;
                ox = round_q(x * c, Q14_BITS) + round_q(-(y * s), Q14_BITS)
                   + round_q(w * e0, Q14_BITS);
                oy = round_q(x * s, Q14_BITS) + round_q(y * c, Q14_BITS)
                   + round_q(w * e1, Q14_BITS);
            end
            default:
            begin
                // spare kinds: identity
                ox = x;
                oy = y;
            end
        endcase
        p.x    = clamp24(ox);
        p.y    = clamp24(oy);
        p.w    = v.w;
        p.last = v.last;
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Reporting
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------------------------------------------------------
    // Slave-side driver: bursts of random length, random gaps between.
    // Expectation is taken at the accepting edge, from the setup in force.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_rows.push_back(transform_vertex(held_vertex));
            // offer slot is free: either nothing held or the held row just went
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || vertex_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    held_vertex = vertex_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'({held_vertex.w, held_vertex.y, held_vertex.x});
                    s_tlast  <= held_vertex.last;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Master-side monitor and back-pressure.
    // m_tdata: out_x [23:0], out_y [47:24], out_w above.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_mode      = RX_FLOW;
            rx_mode_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rows.size() == 0)
                    report_mismatch("result transaction with no vertex outstanding");
                else
                begin
                    want = expected_rows.pop_front();
                    check_field("out_x", $signed(m_tdata[23:0]), want.x);
                    check_field("out_y", $signed(m_tdata[47:24]), want.y);
                    check_field("out_w", $signed(m_tdata[48 +: COORD_W]), want.w);
                    check_field("out_last", m_tlast, want.last);
                end
            end
            if (rx_mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    rx_mode = RX_FLOW;
                    2:       rx_mode = RX_LIGHT;
                    default: rx_mode = RX_HEAVY;
                endcase
                rx_mode_left = $urandom_range(16, 128);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RX_FLOW:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                default:  m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Watchdog: any transaction or register write resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transaction", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic void queue_vertex(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic signed [COORD_W-1:0] w,
                                         input logic last);
        vertex_t v;
        v.x    = x;
        v.y    = y;
        v.w    = w;
        v.last = last;
        vertex_backlog.push_back(v);
    endfunction

    // Returns on a rising edge once every row has come back and the pipe is quiet.
    // The state is sampled at the falling edge, after the driver has settled.
    task automatic wait_drained();
        while (vertex_backlog.size() != 0 || s_tvalid || expected_rows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One write per edge; cfg_we is only lowered after the last one.
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_transform(input logic [2:0] kind,
                                 input logic signed [15:0] ox, input logic signed [15:0] oy,
                                 input logic signed [15:0] sx, input logic signed [15:0] sy,
                                 input logic [8:0] angle);
        wait_drained();
        write_reg(CFG_KIND, {13'd0, kind});
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        write_reg(CFG_ANGLE, {7'd0, angle});
        cfg_we <= 1'b0;
        setup.kind     = kind;
        setup.offset_x = ox;
        setup.offset_y = oy;
        setup.scale_x  = sx;
        setup.scale_y  = sy;
        setup.angle    = angle;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(COORD_W-1){1'b0}}};
            1:       return {1'b0, {(COORD_W-1){1'b1}}};
            2, 3, 4: return COORD_W'(int'($urandom_range(0, 600)) - 300);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Mostly the usual w = 1, sometimes anything.
    function automatic logic signed [COORD_W-1:0] pick_w();
        if ($urandom_range(0, 9) < 7)
            return COORD_W'(1);
        return pick_coord();
    endfunction

    function automatic logic signed [15:0] pick_offset();
        case ($urandom_range(0, 4))
            0:       return 16'(int'($urandom_range(0, 400)) - 200);
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2:       return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_scale();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 512));
            1:       return 16'(int'($urandom_range(0, 2048)) - 1024);
            2:       return 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        int         random_rows;
        int         phase_rows;
        int         fig_left;
        int unsigned pick;
        logic [2:0] kind;
        logic [8:0] angle;

        setup.kind     = KIND_TRANSLATE;
        setup.offset_x = 16'sd0;
        setup.offset_y = 16'sd0;
        setup.scale_x  = 16'sd256;
        setup.scale_y  = 16'sd256;
        setup.angle    = 9'd0;
        random_rows    = 0;
        fig_left       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Register values straight out of reset: translate by zero.
        queue_vertex(16'sh7FFF, 16'sh8000, 16'sd1, 1'b0);
        queue_vertex(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);

        // Extreme translation, large w saturates; zero and negative w used as is.
        set_transform(KIND_TRANSLATE, 16'sh7FFF, 16'sh8000, 16'sd256, 16'sd256, 9'd0);
        queue_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        queue_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_vertex(-16'sd1, 16'sd1, 16'sh8000, 1'b1);

        // Extreme scale factors.
        set_transform(KIND_SCALE, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 9'd0);
        queue_vertex(16'sh7FFF, 16'sh8000, 16'sd1, 1'b0);
        queue_vertex(16'sh8000, 16'sh8000, -16'sd1, 1'b1);

        // Half-way products: +0.5 rounds up, -0.5 rounds to zero.
        set_transform(KIND_SCALE, 16'sd0, 16'sd0, 16'sd128, -16'sd128, 9'd0);
        queue_vertex(16'sd1, -16'sd1, 16'sd1, 1'b0);
        queue_vertex(-16'sd1, 16'sd1, 16'sd1, 1'b1);

        // Pivot scale at the corners of the offset and scale registers.
        set_transform(KIND_SCALE_PIVOT, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 9'd0);
        queue_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        queue_vertex(16'sd0, 16'sd0, 16'sh8000, 1'b1);

        // 30 degrees: sine is exactly one half, so rounding ties show up.
        set_transform(KIND_ROTATE, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 9'd30);
        queue_vertex(16'sd1, 16'sd0, 16'sd1, 1'b0);
        queue_vertex(-16'sd1, 16'sd0, 16'sd1, 1'b0);
        queue_vertex(16'sd0, -16'sd1, 16'sd1, 1'b1);

        // Angle past 359 wraps (405 acts as 45).
        set_transform(KIND_ROTATE_INV, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 9'd405);
        queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sd1, 1'b0);
        queue_vertex(16'sh8000, 16'sh8000, 16'sd1, 1'b1);

        set_transform(KIND_ROTATE_PIVOT, 16'sh7FFF, 16'sh8000, 16'sd256, 16'sd256, 9'd180);
        queue_vertex(16'sd0, 16'sd0, 16'sh7FFF, 1'b0);
        queue_vertex(16'sd100, 16'sd200, 16'sd1, 1'b1);

        // Largest angle code.
        set_transform(KIND_ROTATE, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 9'd511);
        queue_vertex(16'sd12345, -16'sd23456, 16'sd1, 1'b1);

        // Spare kind codes pass x and y through.
        set_transform(KIND_SPARE_6, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 9'd359);
        queue_vertex(16'sh8000, 16'sh7FFF, 16'sd5, 1'b0);
        set_transform(KIND_SPARE_7, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 9'd90);
        queue_vertex(16'sh7FFF, 16'sh8000, -16'sd5, 1'b1);

        // Random phases: fresh setup each time, figures of 1..8 rows.
        while (random_rows < RANDOM_ROWS)
        begin
            pick = $urandom_range(0, 13);
            kind = (pick < 12) ? 3'(pick % 6) : 3'(pick - 6);
            angle = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                                : 9'($urandom_range(0, 359));
            set_transform(kind, pick_offset(), pick_offset(), pick_scale(), pick_scale(),
                          angle);
            phase_rows = $urandom_range(20, 80);
            for (int k = 0; k < phase_rows; k++)
            begin
                if (fig_left == 0)
                    fig_left = $urandom_range(1, 8);
                fig_left--;
                queue_vertex(pick_coord(), pick_coord(), pick_w(), fig_left == 0);
            end
            random_rows += phase_rows;
        end

        wait_drained();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
